// ===== rtl/core/rtttl_pkg.sv =====
// Shared types, character codes, note table and helpers for the ringtone parser.
`timescale 1ns / 1ps

package rtttl_pkg;

	localparam int NUM_W = 23;   // note length times 60000
	localparam int DEN_W = 19;   // beats per minute times 8
	localparam int CNT_W = 5;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SHARP = 8'h23;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] KEY_D    = 8'h64;
	localparam logic [7:0] KEY_O    = 8'h6F;
	localparam logic [7:0] KEY_B    = 8'h62;

	localparam logic [5:0]  DDUR_RST = 6'd8;
	localparam logic [2:0]  DOCT_RST = 3'd6;
	localparam logic [15:0] BPM_RST  = 16'd63;
	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [22:0] WHOLE_32 = 23'd32;

	typedef enum logic [3:0] {
		PH_NAME    = 4'd0,
		PH_KEY     = 4'd1,
		PH_EQ      = 4'd2,
		PH_VAL     = 4'd3,
		PH_AFTER   = 4'd4,
		PH_ABORT   = 4'd5,
		PH_NSTART  = 4'd6,
		PH_NDIGITS = 4'd7,
		PH_NLETTER = 4'd8,
		PH_NSHARP  = 4'd9,
		PH_NDOT    = 4'd10,
		PH_NSCALE  = 4'd11,
		PH_NTAIL   = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE, C_STEP, C_DIV, C_MUL, C_TSTART, C_EMIT1, C_EMIT2
	} ctl_t;

	typedef enum logic [1:0] {
		DK_CTRL, DK_NOTE, DK_TIME
	} div_kind_t;

	typedef struct packed {
		logic done;
		logic div;
		logic emit;
	} act_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Decimal accumulate with saturation at the top of 16 bits.
	function automatic logic [15:0] acc_next(input logic [15:0] acc, input logic [7:0] c);
		logic [20:0] v;
		v = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0} + {13'd0, c - CH_ZERO};
		return (v > 21'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [3:0] pitch_of(input logic [7:0] c);
		logic [3:0] p;
		case (c)
			8'h63, 8'h43: p = 4'd1;
			8'h64, 8'h44: p = 4'd3;
			8'h65, 8'h45: p = 4'd5;
			8'h66, 8'h46: p = 4'd6;
			8'h67, 8'h47: p = 4'd8;
			8'h61, 8'h41: p = 4'd10;
			8'h62, 8'h42, 8'h68, 8'h48: p = 4'd12;
			default: p = 4'd0;
		endcase
		return p;
	endfunction

	function automatic logic [6:0] add_dot(input logic [6:0] d);
		return d + {1'b0, d[6:1]};
	endfunction

	// s is octave * 12 + pitch; the table covers s = 49..96.
	function automatic logic [11:0] tone_freq(input logic [7:0] s);
		logic [11:0] f;
		case (s)
			8'd49: f = 12'd262;  8'd50: f = 12'd277;  8'd51: f = 12'd294;
			8'd52: f = 12'd311;  8'd53: f = 12'd330;  8'd54: f = 12'd349;
			8'd55: f = 12'd370;  8'd56: f = 12'd392;  8'd57: f = 12'd415;
			8'd58: f = 12'd440;  8'd59: f = 12'd466;  8'd60: f = 12'd494;
			8'd61: f = 12'd523;  8'd62: f = 12'd554;  8'd63: f = 12'd587;
			8'd64: f = 12'd622;  8'd65: f = 12'd659;  8'd66: f = 12'd698;
			8'd67: f = 12'd740;  8'd68: f = 12'd784;  8'd69: f = 12'd831;
			8'd70: f = 12'd880;  8'd71: f = 12'd932;  8'd72: f = 12'd988;
			8'd73: f = 12'd1047; 8'd74: f = 12'd1109; 8'd75: f = 12'd1175;
			8'd76: f = 12'd1245; 8'd77: f = 12'd1319; 8'd78: f = 12'd1397;
			8'd79: f = 12'd1480; 8'd80: f = 12'd1568; 8'd81: f = 12'd1661;
			8'd82: f = 12'd1760; 8'd83: f = 12'd1865; 8'd84: f = 12'd1976;
			8'd85: f = 12'd2093; 8'd86: f = 12'd2217; 8'd87: f = 12'd2349;
			8'd88: f = 12'd2489; 8'd89: f = 12'd2637; 8'd90: f = 12'd2794;
			8'd91: f = 12'd2960; 8'd92: f = 12'd3136; 8'd93: f = 12'd3322;
			8'd94: f = 12'd3520; 8'd95: f = 12'd3729; 8'd96: f = 12'd3951;
			default: f = 12'd0;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/core/rtttl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rtttl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rtttl_pkg::NUM_W-1:0]   numer,
	input  logic [rtttl_pkg::DEN_W-1:0]   denom,
	output logic                          busy,
	output logic                          done,
	output logic [rtttl_pkg::NUM_W-1:0]   quot
);

	logic [rtttl_pkg::DEN_W-1:0] rem_q;
	logic [rtttl_pkg::DEN_W-1:0] den_q;
	logic [rtttl_pkg::NUM_W-1:0] quo_q;
	logic [rtttl_pkg::CNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rtttl_pkg::DEN_W:0]   shifted;
	logic [rtttl_pkg::DEN_W+1:0] diff;
	logic                        ge;

	assign shifted = {rem_q, quo_q[rtttl_pkg::NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[rtttl_pkg::DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rtttl_pkg::CNT_W'(rtttl_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			quo_q <= numer;
		end else if (busy_q) begin
			rem_q <= ge ? diff[rtttl_pkg::DEN_W-1:0] : shifted[rtttl_pkg::DEN_W-1:0];
			quo_q <= {quo_q[rtttl_pkg::NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/core/rtttl_tone_command_parser.sv =====
// Ringtone text parser: sequencer, parse state, shared divider and command output.
// Plain characters need no division; a d= value or a nonzero note length goes through
// the 23-step divider, as does a finished note's time (when b is nonzero) before its first command.
// Throughput: one character at a time; the next is taken once the current one is finished.
// Reset: asynchronous, active low; parser returns to skipping the name, defaults d=8, o=6, b=63.
// A command waiting in the output register does not stop the sequencer until the next one.
`timescale 1ns / 1ps

module rtttl_tone_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output logic [11:0] frequency_hz,
	output logic [19:0] time_ms,
	output logic        last_of_run
);

	rtttl_pkg::ctl_t      ctl_q, ctl_d;
	rtttl_pkg::phase_t    phase_q, phase_d;
	rtttl_pkg::div_kind_t kind_q, kind_d;
	rtttl_pkg::act_t      act;

	logic [7:0]  char_q;
	logic [7:0]  key_q, key_d;
	logic [15:0] acc_q, acc_d;
	logic [5:0]  ddur_q, ddur_d;
	logic [2:0]  doct_q, doct_d;
	logic [15:0] bpm_q, bpm_d;
	logic [6:0]  ndur_q, ndur_d;
	logic [3:0]  pitch_q, pitch_d;
	logic [3:0]  noct_q, noct_d;
	logic        end_q, end_d;
	logic [22:0] prod_q;
	logic [22:0] t_q, t_d;

	logic        out_valid_q;
	logic [11:0] out_freq_q;
	logic [19:0] out_time_q;
	logic        out_last_q;
	logic        load;
	logic [11:0] load_freq;
	logic [19:0] load_time;
	logic        load_last;
	logic        out_free;

	logic        div_start;
	logic [22:0] div_numer;
	logic [18:0] div_denom;
	logic        div_busy;
	logic        div_done;
	logic [22:0] div_quot;

	logic        finish;
	logic [25:0] t_x7;
	logic [7:0]  tone_idx;
	logic        in_note;

	assign out_free  = !out_valid_q || cmd_ready;
	assign t_x7      = {t_q, 3'b000} - {3'b000, t_q};
	assign tone_idx  = 8'(noct_q) * 8'd12 + 8'(pitch_q);
	assign in_note   = (phase_q == rtttl_pkg::PH_NLETTER) || (phase_q == rtttl_pkg::PH_NSHARP)
		|| (phase_q == rtttl_pkg::PH_NDOT) || (phase_q == rtttl_pkg::PH_NSCALE)
		|| (phase_q == rtttl_pkg::PH_NTAIL);
	assign finish    = ((ctl_q == rtttl_pkg::C_EMIT1) && out_free && (pitch_q == 4'd0))
		|| ((ctl_q == rtttl_pkg::C_EMIT2) && out_free);

	rtttl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Parse step, divider requests and command loads
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		key_d     = key_q;
		acc_d     = acc_q;
		ddur_d    = ddur_q;
		doct_d    = doct_q;
		bpm_d     = bpm_q;
		ndur_d    = ndur_q;
		pitch_d   = pitch_q;
		noct_d    = noct_q;
		end_d     = end_q;
		t_d       = t_q;
		act       = '0;
		div_start = 1'b0;
		div_numer = rtttl_pkg::WHOLE_32;
		div_denom = {3'b000, acc_q};
		load      = 1'b0;
		load_freq = 12'd0;
		load_time = t_q[19:0];
		load_last = 1'b1;
		unique case (ctl_q)
			rtttl_pkg::C_STEP: begin
				if (char_q == rtttl_pkg::CH_END) begin
					if (in_note) begin
						end_d    = 1'b1;
						act.emit = 1'b1;
					end else begin
						act.done = 1'b1;
						end_d    = 1'b1;
					end
				end else begin
					case (phase_q)
						rtttl_pkg::PH_NAME: begin
							if (char_q == rtttl_pkg::CH_COLON) phase_d = rtttl_pkg::PH_KEY;
							act.done = 1'b1;
						end
						rtttl_pkg::PH_KEY: begin
							act.done = 1'b1;
							if (char_q == rtttl_pkg::CH_COLON) begin
								phase_d = rtttl_pkg::PH_NSTART;
							end else if (char_q != rtttl_pkg::CH_SPACE) begin
								key_d   = char_q;
								phase_d = rtttl_pkg::PH_EQ;
							end
						end
						rtttl_pkg::PH_EQ: begin
							act.done = 1'b1;
							if (char_q == rtttl_pkg::CH_EQ) begin
								acc_d   = '0;
								phase_d = rtttl_pkg::PH_VAL;
							end else begin
								phase_d = rtttl_pkg::PH_ABORT;
							end
						end
						rtttl_pkg::PH_VAL: begin
							if (rtttl_pkg::is_digit(char_q)) begin
								acc_d    = rtttl_pkg::acc_next(acc_q, char_q);
								act.done = 1'b1;
							end else begin
								phase_d = rtttl_pkg::PH_AFTER;
								if (key_q == rtttl_pkg::KEY_D && acc_q != 16'd0) begin
									act.div   = 1'b1;
									div_start = 1'b1;
									kind_d    = rtttl_pkg::DK_CTRL;
								end else if (key_q == rtttl_pkg::KEY_O) begin
									if (acc_q >= 16'd4 && acc_q <= 16'd7) doct_d = acc_q[2:0];
								end else if (key_q == rtttl_pkg::KEY_B) begin
									bpm_d = acc_q;
								end
							end
						end
						rtttl_pkg::PH_AFTER: begin
							if (char_q == rtttl_pkg::CH_SPACE) begin
								act.done = 1'b1;
							end else begin
								phase_d  = rtttl_pkg::PH_KEY;
								act.done = (char_q == rtttl_pkg::CH_COMMA);
							end
						end
						rtttl_pkg::PH_NSTART: begin
							act.done = 1'b1;
							if (char_q != rtttl_pkg::CH_SPACE) begin
								ndur_d  = {1'b0, ddur_q};
								noct_d  = {1'b0, doct_q};
								pitch_d = 4'd0;
								if (rtttl_pkg::is_digit(char_q)) begin
									acc_d   = {8'd0, char_q - rtttl_pkg::CH_ZERO};
									phase_d = rtttl_pkg::PH_NDIGITS;
								end else begin
									pitch_d = rtttl_pkg::pitch_of(char_q);
									phase_d = rtttl_pkg::PH_NLETTER;
								end
							end
						end
						rtttl_pkg::PH_NDIGITS: begin
							if (rtttl_pkg::is_digit(char_q)) begin
								acc_d    = rtttl_pkg::acc_next(acc_q, char_q);
								act.done = 1'b1;
							end else begin
								pitch_d = rtttl_pkg::pitch_of(char_q);
								phase_d = rtttl_pkg::PH_NLETTER;
								if (acc_q != 16'd0) begin
									act.div   = 1'b1;
									div_start = 1'b1;
									kind_d    = rtttl_pkg::DK_NOTE;
								end else begin
									act.done = 1'b1;
								end
							end
						end
						rtttl_pkg::PH_NLETTER: begin
							phase_d = rtttl_pkg::PH_NSHARP;
							if (char_q == rtttl_pkg::CH_SHARP) begin
								pitch_d  = pitch_q + 4'd1;
								act.done = 1'b1;
							end
						end
						rtttl_pkg::PH_NSHARP: begin
							phase_d = rtttl_pkg::PH_NDOT;
							if (char_q == rtttl_pkg::CH_DOT) begin
								ndur_d   = rtttl_pkg::add_dot(ndur_q);
								act.done = 1'b1;
							end
						end
						rtttl_pkg::PH_NDOT: begin
							phase_d = rtttl_pkg::PH_NSCALE;
							if (rtttl_pkg::is_digit(char_q)) begin
								noct_d   = 4'(char_q - rtttl_pkg::CH_ZERO);
								act.done = 1'b1;
							end
						end
						rtttl_pkg::PH_NSCALE: begin
							phase_d = rtttl_pkg::PH_NTAIL;
							if (char_q == rtttl_pkg::CH_DOT) begin
								ndur_d   = rtttl_pkg::add_dot(ndur_q);
								act.done = 1'b1;
							end
						end
						rtttl_pkg::PH_NTAIL: begin
							if (char_q == rtttl_pkg::CH_SPACE) act.done = 1'b1;
							else act.emit = 1'b1;
						end
						default: act.done = 1'b1;
					endcase
				end
			end
			rtttl_pkg::C_DIV: begin
				if (div_done) begin
					case (kind_q)
						rtttl_pkg::DK_CTRL: ddur_d = div_quot[5:0];
						rtttl_pkg::DK_NOTE: ndur_d = div_quot[6:0];
						default:            t_d    = div_quot;
					endcase
				end
			end
			rtttl_pkg::C_TSTART: begin
				div_numer = prod_q;
				div_denom = {bpm_q, 3'b000};
				if (bpm_q == 16'd0) begin
					t_d = '0;
				end else begin
					div_start = 1'b1;
					kind_d    = rtttl_pkg::DK_TIME;
				end
			end
			rtttl_pkg::C_EMIT1: begin
				if (out_free) begin
					load = 1'b1;
					if (pitch_q != 4'd0) begin
						load_freq = rtttl_pkg::tone_freq(tone_idx);
						load_time = t_x7[22:3];
						load_last = 1'b0;
					end
				end
			end
			rtttl_pkg::C_EMIT2: begin
				if (out_free) begin
					load      = 1'b1;
					load_time = t_q[22:3];
				end
			end
			default: ;
		endcase
		if (finish) phase_d = rtttl_pkg::PH_NSTART;
	end

	// Sequencer next state
	always_comb begin
		ctl_d = ctl_q;
		unique case (ctl_q)
			rtttl_pkg::C_IDLE:
				if (char_valid) ctl_d = rtttl_pkg::C_STEP;
			rtttl_pkg::C_STEP: begin
				if (act.div) ctl_d = rtttl_pkg::C_DIV;
				else if (act.emit) ctl_d = rtttl_pkg::C_MUL;
				else if (act.done) ctl_d = rtttl_pkg::C_IDLE;
			end
			rtttl_pkg::C_DIV: begin
				if (div_done) begin
					case (kind_q)
						rtttl_pkg::DK_CTRL: ctl_d = rtttl_pkg::C_STEP;
						rtttl_pkg::DK_NOTE: ctl_d = rtttl_pkg::C_IDLE;
						default:            ctl_d = rtttl_pkg::C_EMIT1;
					endcase
				end
			end
			rtttl_pkg::C_MUL: ctl_d = rtttl_pkg::C_TSTART;
			rtttl_pkg::C_TSTART:
				ctl_d = (bpm_q == 16'd0) ? rtttl_pkg::C_EMIT1 : rtttl_pkg::C_DIV;
			rtttl_pkg::C_EMIT1, rtttl_pkg::C_EMIT2: begin
				if (finish) begin
					ctl_d = (end_q || char_q == rtttl_pkg::CH_COMMA) ? rtttl_pkg::C_IDLE
						: rtttl_pkg::C_STEP;
				end else if (ctl_q == rtttl_pkg::C_EMIT1 && out_free) begin
					ctl_d = rtttl_pkg::C_EMIT2;
				end
			end
			default: ctl_d = rtttl_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= rtttl_pkg::C_IDLE;
			phase_q     <= rtttl_pkg::PH_NAME;
			kind_q      <= rtttl_pkg::DK_CTRL;
			key_q       <= '0;
			acc_q       <= '0;
			ddur_q      <= rtttl_pkg::DDUR_RST;
			doct_q      <= rtttl_pkg::DOCT_RST;
			bpm_q       <= rtttl_pkg::BPM_RST;
			ndur_q      <= '0;
			pitch_q     <= '0;
			noct_q      <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_q  <= ctl_d;
			kind_q <= kind_d;
			// end of tune: drop all parse state back to its reset values
			if (end_d && (act.done || (finish && end_q))) begin
				phase_q <= rtttl_pkg::PH_NAME;
				key_q   <= '0;
				acc_q   <= '0;
				ddur_q  <= rtttl_pkg::DDUR_RST;
				doct_q  <= rtttl_pkg::DOCT_RST;
				bpm_q   <= rtttl_pkg::BPM_RST;
				ndur_q  <= '0;
				pitch_q <= '0;
				noct_q  <= '0;
				end_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				key_q   <= key_d;
				acc_q   <= acc_d;
				ddur_q  <= ddur_d;
				doct_q  <= doct_d;
				bpm_q   <= bpm_d;
				ndur_q  <= ndur_d;
				pitch_q <= pitch_d;
				noct_q  <= noct_d;
				end_q   <= end_d;
			end
			if (load) out_valid_q <= 1'b1;
			else if (cmd_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) char_q <= char_code;
		if (ctl_q == rtttl_pkg::C_MUL) prod_q <= 23'(ndur_q) * 23'(rtttl_pkg::MS_PER_MIN);
		t_q <= t_d;
		if (load) begin
			out_freq_q <= load_freq;
			out_time_q <= load_time;
			out_last_q <= load_last;
		end
	end

	assign char_ready   = (ctl_q == rtttl_pkg::C_IDLE);
	assign cmd_valid    = out_valid_q;
	assign frequency_hz = out_freq_q;
	assign time_ms      = out_time_q;
	assign last_of_run  = out_last_q;

`ifndef SYNTHESIS
	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !last_of_run) |-> (ctl_q == rtttl_pkg::C_EMIT2))
		else $error("first half of a tone pending outside its second emit step");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		char_ready |-> !div_busy)
		else $error("divider busy while taking a new character");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (ctl_q == rtttl_pkg::C_DIV))
		else $error("divider finished while sequencer not waiting");
	a_emit_note: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == rtttl_pkg::C_EMIT1) |-> in_note)
		else $error("emitting a command outside a note");
`endif

endmodule
